/* rtl/token_lexer_line_column_macros.svh */
// Assertion macros shared by the lexer RTL files.
// No dependencies; included at the top of the RTL files that check themselves.
`ifndef TOKEN_LEXER_LINE_COLUMN_MACROS_SVH
`define TOKEN_LEXER_LINE_COLUMN_MACROS_SVH

// Clocked check, disabled while the synchronous active-low reset is asserted.
`define TLLC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked check that also holds during reset.
`define TLLC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* rtl/tllc_pkg.sv */
// Shared types and constants of the line/column token lexer.
// Used by tllc_out_fifo and token_lexer_line_column; no dependencies.
package tllc_pkg;

    // Token kind codes as they appear on the result beat.
    typedef enum logic [3:0] {
        KIND_LPAREN = 4'd0,
        KIND_RPAREN = 4'd1,
        KIND_ASSIGN = 4'd2,
        KIND_DOT    = 4'd3,
        KIND_LET    = 4'd4,
        KIND_NAT    = 4'd5,
        KIND_ID     = 4'd6,
        KIND_END    = 4'd7,
        KIND_ERR    = 4'd8
    } t_kind;

    // Character codes the lexer recognizes.
    localparam logic [7:0] CH_NUL        = 8'h00;
    localparam logic [7:0] CH_TAB        = 8'h09;
    localparam logic [7:0] CH_NEWLINE    = 8'h0A;
    localparam logic [7:0] CH_CR         = 8'h0D;
    localparam logic [7:0] CH_SPACE      = 8'h20;
    localparam logic [7:0] CH_LPAREN     = 8'h28;
    localparam logic [7:0] CH_RPAREN     = 8'h29;
    localparam logic [7:0] CH_DOT        = 8'h2E;
    localparam logic [7:0] CH_ZERO       = 8'h30;
    localparam logic [7:0] CH_NINE       = 8'h39;
    localparam logic [7:0] CH_ASSIGN     = 8'h3D;
    localparam logic [7:0] CH_UPPER_A    = 8'h41;
    localparam logic [7:0] CH_UPPER_Z    = 8'h5A;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_LOWER_A    = 8'h61;
    localparam logic [7:0] CH_LOWER_E    = 8'h65;
    localparam logic [7:0] CH_LOWER_L    = 8'h6C;
    localparam logic [7:0] CH_LOWER_T    = 8'h74;
    localparam logic [7:0] CH_LOWER_Z    = 8'h7A;

    // Keyword match progress: nothing, "l", "le", "let".
    localparam logic [1:0] KW_NONE = 2'd0;
    localparam logic [1:0] KW_L    = 2'd1;
    localparam logic [1:0] KW_LE   = 2'd2;
    localparam logic [1:0] KW_LET  = 2'd3;

    // Result field widths and length saturation limit.
    localparam int unsigned FIELD_W = 16;
    localparam logic [FIELD_W-1:0] LEN_MAX = '1;

    // Output queue geometry.
    localparam int unsigned OUT_DEPTH = 4;
    localparam int unsigned OUT_PTR_W = $clog2(OUT_DEPTH);
    localparam int unsigned OUT_CNT_W = $clog2(OUT_DEPTH + 1);

    // One result item.
    typedef struct packed {
        t_kind              kind;
        logic [FIELD_W-1:0] line;
        logic [FIELD_W-1:0] column;
        logic [FIELD_W-1:0] length;
        logic               last;
    } t_result;

    // Results produced by one accepted byte, in order.
    typedef struct packed {
        logic [1:0] count;
        t_result    first;
        t_result    second;
    } t_push;

endpackage

/* rtl/token_lexer_line_column.sv */
// Streaming byte lexer: groups source bytes into tokens with start line, column and length.
// Depends on tllc_pkg, tllc_out_fifo and token_lexer_line_column_macros.svh.
//
// Usage:
//   Source bytes enter on the s_axis channel, one byte per beat in s_axis_tdata[7:0].
//   Tokens leave on the m_axis channel. Each byte causes zero, one or two results;
//   m_axis_tlast marks the final result caused by a byte. A NUL byte flushes any
//   open token, sends an end result and restarts at line 1, column 1. An illegal
//   byte sends an error result and the lexer ignores input until the next NUL.
// Output: a result is registered in the output queue and waits there behind earlier ones.
// Throughput: one byte per cycle while s_axis_tready is high. The byte decode and the
//   line/column update run combinationally against the state registers; the limit is
//   the output port, which moves one result per cycle while m_axis_tready is high, so
//   a byte that closes a token and emits its own result needs the port for both.
// Stalls: results wait in a four-entry queue. s_axis_tready stays high while the
//   queue holds at most two results, so input keeps flowing while a result waits.
// Reset: synchronous, active low; clears the queue and the scan state to line 1,
//   column 1, no open token.
`include "token_lexer_line_column_macros.svh"

module token_lexer_line_column #(
    parameter int unsigned POS_WIDTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,  // [7:0] ch
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,  // [3:0] token_kind, [19:4] start_line,
                                       // [35:20] start_column, [51:36] token_length,
                                       // [55:52] zero
    output logic        m_axis_tlast   // last
);
    import tllc_pkg::*;

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_NUM,
        MODE_ID,
        MODE_HALT
    } t_mode;

    localparam logic [POS_WIDTH-1:0] POS_MAX = '1;
    localparam logic [POS_WIDTH-1:0] POS_ONE = {{(POS_WIDTH-1){1'b0}}, 1'b1};

    t_mode                r_mode,   n_mode;
    logic [POS_WIDTH-1:0] r_line,   n_line;
    logic [POS_WIDTH-1:0] r_col,    n_col;
    logic [POS_WIDTH-1:0] r_pstart, n_pstart;
    logic [FIELD_W-1:0]   r_plen,   n_plen;
    logic [1:0]           r_kp,     n_kp;

    logic                 w_in_acc;
    logic [7:0]           w_ch;
    logic                 w_digit, w_alpha, w_word, w_space, w_punct;
    logic [POS_WIDTH-1:0] w_col_inc, w_line_inc;
    logic [FIELD_W-1:0]   w_plen_inc;
    logic [POS_WIDTH+FIELD_W-1:0] w_line_ext, w_col_ext, w_pstart_ext;
    logic [FIELD_W-1:0]   w_line16, w_col16, w_pstart16;
    t_kind                w_punct_kind;
    logic [1:0]           w_kp_next;
    t_result              w_flush_res, w_own_res;
    logic                 w_flush_v, w_own_v;
    t_push                w_push;
    logic                 w_room;
    t_result              w_out;

    function automatic t_result make_res(t_kind kind, logic [FIELD_W-1:0] line,
                                         logic [FIELD_W-1:0] column,
                                         logic [FIELD_W-1:0] length);
        t_result res;
        res.kind   = kind;
        res.line   = line;
        res.column = column;
        res.length = length;
        res.last   = 1'b1;
        return res;
    endfunction

    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = w_room;
    assign w_ch          = s_axis_tdata;

    // Byte class decode.
    assign w_digit = (w_ch >= CH_ZERO) && (w_ch <= CH_NINE);
    assign w_alpha = ((w_ch >= CH_LOWER_A) && (w_ch <= CH_LOWER_Z)) ||
                     ((w_ch >= CH_UPPER_A) && (w_ch <= CH_UPPER_Z));
    assign w_word  = w_alpha || w_digit || (w_ch == CH_UNDERSCORE);
    assign w_space = (w_ch == CH_SPACE) || ((w_ch >= CH_TAB) && (w_ch <= CH_CR));
    assign w_punct = (w_ch == CH_LPAREN) || (w_ch == CH_RPAREN) ||
                     (w_ch == CH_ASSIGN) || (w_ch == CH_DOT);

    always_comb begin
        case (w_ch)
            CH_LPAREN: w_punct_kind = KIND_LPAREN;
            CH_RPAREN: w_punct_kind = KIND_RPAREN;
            CH_ASSIGN: w_punct_kind = KIND_ASSIGN;
            default:   w_punct_kind = KIND_DOT;
        endcase
    end

    // Keyword tracking inside an identifier.
    always_comb begin
        if (r_kp == KW_L && w_ch == CH_LOWER_E) begin
            w_kp_next = KW_LE;
        end else if (r_kp == KW_LE && w_ch == CH_LOWER_T) begin
            w_kp_next = KW_LET;
        end else begin
            w_kp_next = KW_NONE;
        end
    end

    // Saturating counters.
    assign w_col_inc  = (r_col == POS_MAX) ? r_col : r_col + POS_ONE;
    assign w_line_inc = (r_line == POS_MAX) ? r_line : r_line + POS_ONE;
    assign w_plen_inc = (r_plen == LEN_MAX) ? r_plen : r_plen + FIELD_W'(1);

    // Positions are reported in the low bits of the result fields.
    assign w_line_ext   = {{FIELD_W{1'b0}}, r_line};
    assign w_col_ext    = {{FIELD_W{1'b0}}, r_col};
    assign w_pstart_ext = {{FIELD_W{1'b0}}, r_pstart};
    assign w_line16     = w_line_ext[FIELD_W-1:0];
    assign w_col16      = w_col_ext[FIELD_W-1:0];
    assign w_pstart16   = w_pstart_ext[FIELD_W-1:0];

    // Next scan state and the results caused by the accepted byte.
    always_comb begin
        n_mode      = r_mode;
        n_line      = r_line;
        n_col       = r_col;
        n_pstart    = r_pstart;
        n_plen      = r_plen;
        n_kp        = r_kp;
        w_flush_v   = 1'b0;
        w_own_v     = 1'b0;
        w_flush_res = make_res((r_mode == MODE_ID) ?
                               ((r_kp == KW_LET) ? KIND_LET : KIND_ID) : KIND_NAT,
                               w_line16, w_pstart16, r_plen);
        w_own_res   = make_res(KIND_END, w_line16, w_col16, '0);
        if (w_in_acc) begin
            if (r_mode == MODE_HALT) begin
                if (w_ch == CH_NUL) begin
                    w_own_v  = 1'b1;
                    n_mode   = MODE_IDLE;
                    n_line   = POS_ONE;
                    n_col    = POS_ONE;
                    n_pstart = '0;
                    n_plen   = '0;
                    n_kp     = KW_NONE;
                end
            end else if (r_mode == MODE_NUM && w_digit) begin
                n_plen = w_plen_inc;
                n_col  = w_col_inc;
            end else if (r_mode == MODE_ID && w_word) begin
                n_plen = w_plen_inc;
                n_kp   = w_kp_next;
                n_col  = w_col_inc;
            end else begin
                // An open token is closed by this byte and goes out first.
                if (r_mode == MODE_NUM || r_mode == MODE_ID) begin
                    w_flush_v = 1'b1;
                    n_mode    = MODE_IDLE;
                    n_pstart  = '0;
                    n_plen    = '0;
                    n_kp      = KW_NONE;
                end
                if (w_ch == CH_NUL) begin
                    w_own_v  = 1'b1;
                    n_mode   = MODE_IDLE;
                    n_line   = POS_ONE;
                    n_col    = POS_ONE;
                end else if (w_punct) begin
                    w_own_v   = 1'b1;
                    w_own_res = make_res(w_punct_kind, w_line16, w_col16, FIELD_W'(1));
                    n_col     = w_col_inc;
                end else if (w_digit) begin
                    n_mode   = MODE_NUM;
                    n_pstart = r_col;
                    n_plen   = FIELD_W'(1);
                    n_col    = w_col_inc;
                end else if (w_alpha || w_ch == CH_UNDERSCORE) begin
                    n_mode   = MODE_ID;
                    n_pstart = r_col;
                    n_plen   = FIELD_W'(1);
                    n_kp     = (w_ch == CH_LOWER_L) ? KW_L : KW_NONE;
                    n_col    = w_col_inc;
                end else if (w_space) begin
                    if (w_ch == CH_NEWLINE) begin
                        n_line = w_line_inc;
                        n_col  = POS_ONE;
                    end else begin
                        n_col = w_col_inc;
                    end
                end else begin
                    w_own_v   = 1'b1;
                    w_own_res = make_res(KIND_ERR, w_line16, w_col16, FIELD_W'(1));
                    n_mode    = MODE_HALT;
                end
            end
        end
    end

    // Order the results into the queue push; tlast goes on the final one.
    always_comb begin
        w_push        = '0;
        w_push.first  = w_own_res;
        w_push.second = w_own_res;
        if (w_flush_v) begin
            w_push.first      = w_flush_res;
            w_push.first.last = !w_own_v;
            w_push.count      = w_own_v ? 2'd2 : 2'd1;
        end else if (w_own_v) begin
            w_push.count = 2'd1;
        end
    end

    // Scan state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_IDLE;
            r_line   <= POS_ONE;
            r_col    <= POS_ONE;
            r_pstart <= '0;
            r_plen   <= '0;
            r_kp     <= KW_NONE;
        end else begin
            r_mode   <= n_mode;
            r_line   <= n_line;
            r_col    <= n_col;
            r_pstart <= n_pstart;
            r_plen   <= n_plen;
            r_kp     <= n_kp;
        end
    end

    tllc_out_fifo u_out_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .o_room   (w_room),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_result (w_out)
    );

    assign m_axis_tdata = {4'b0000, w_out.length, w_out.column, w_out.line, w_out.kind};
    assign m_axis_tlast = w_out.last;

    `TLLC_ASSERT(a_halt_silent, i_clk, i_rst_n, (r_mode == MODE_HALT && w_in_acc && w_ch != CH_NUL) |-> (w_push.count == 2'd0 && n_mode == MODE_HALT), "halted lexer produced output")
    `TLLC_ASSERT(a_nul_restart, i_clk, i_rst_n, (w_in_acc && w_ch == CH_NUL) |=> (r_mode == MODE_IDLE && r_line == POS_ONE && r_col == POS_ONE), "NUL did not restart position")
    `TLLC_ASSERT_ALWAYS(a_no_push_idle, i_clk, !w_in_acc |-> (w_push.count == 2'd0), "result pushed without an accepted byte")
    `TLLC_ASSERT(a_open_token_len, i_clk, i_rst_n, (r_mode == MODE_NUM || r_mode == MODE_ID) |-> (r_plen != '0), "open token with zero length")

endmodule

/* rtl/tllc_out_fifo.sv */
// Small result queue that takes up to two results per cycle and hands out one per beat.
// Depends on tllc_pkg and token_lexer_line_column_macros.svh.
`include "token_lexer_line_column_macros.svh"

module tllc_out_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  tllc_pkg::t_push  i_push,
    output logic             o_room,
    output logic             o_tvalid,
    input  logic             i_tready,
    output tllc_pkg::t_result o_result
);
    import tllc_pkg::*;

    t_result              r_mem [OUT_DEPTH];
    logic [OUT_PTR_W-1:0] r_wr_ptr;
    logic [OUT_PTR_W-1:0] r_rd_ptr;
    logic [OUT_CNT_W-1:0] r_count;
    logic [OUT_PTR_W-1:0] w_wr_ptr_next;
    logic                 w_pop;

    assign w_pop         = o_tvalid && i_tready;
    assign w_wr_ptr_next = r_wr_ptr + OUT_PTR_W'(1);

    // Room for the worst case of two results from the next byte.
    assign o_room   = (r_count <= OUT_CNT_W'(OUT_DEPTH - 2));
    assign o_tvalid = (r_count != '0);
    assign o_result = r_mem[r_rd_ptr];

    // Storage writes; no reset needed for payload.
    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.first;
        end
        if (i_push.count == 2'd2) begin
            r_mem[w_wr_ptr_next] <= i_push.second;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + OUT_PTR_W'(i_push.count);
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + OUT_PTR_W'(1);
            end
            r_count <= r_count + OUT_CNT_W'(i_push.count) - OUT_CNT_W'(w_pop);
        end
    end

    `TLLC_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= OUT_CNT_W'(OUT_DEPTH), "result queue overflow")
    `TLLC_ASSERT(a_push_room, i_clk, i_rst_n, (i_push.count != 2'd0) |-> o_room, "push without room")
    `TLLC_ASSERT(a_pop_only, i_clk, i_rst_n, (w_pop && i_push.count == 2'd0) |=> (r_count == $past(r_count) - OUT_CNT_W'(1)), "pop did not drain one entry")

endmodule
